>>> hdl/d4opt_pkg.sv
package d4opt_pkg;

	localparam int TOTAL_W = 13;
	localparam int BYTE_W  = 8;

	localparam logic [BYTE_W-1:0] TYPE_PAD = 8'h00;
	localparam logic [BYTE_W-1:0] TYPE_END = 8'hFF;

	typedef enum logic [3:0] {
		PH_TYPE  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		EV_PAD     = 3'd0,
		EV_TYPE    = 3'd1,
		EV_LENGTH  = 3'd2,
		EV_VALUE   = 3'd3,
		EV_END     = 3'd4,
		EV_TRUNC   = 3'd5,
		EV_IGNORED = 3'd6
	} evt_t;

	typedef struct packed {
		phase_t              phase;
		logic [BYTE_W-1:0]   current_type;
		logic [BYTE_W-1:0]   current_length;
		logic [BYTE_W-1:0]   value_count;
		logic [TOTAL_W-1:0]  byte_position;
		logic [TOTAL_W-1:0]  option_start;
		logic [TOTAL_W-1:0]  stop_offset;
	} parse_state_t;

	typedef struct packed {
		evt_t                event_res;
		logic [BYTE_W-1:0]   option_type;
		logic [BYTE_W-1:0]   option_length;
		logic [BYTE_W-1:0]   value_index;
		logic [BYTE_W-1:0]   value_byte;
		logic                option_done;
		logic                buffer_done;
		logic [TOTAL_W-1:0]  consumed;
	} parse_result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:          PH_TYPE,
		current_type:   '0,
		current_length: '0,
		value_count:    '0,
		byte_position:  '0,
		option_start:   '0,
		stop_offset:    '0
	};

endpackage

>>> hdl/d4opt_byte_if.sv
interface d4opt_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [12:0] total_length;

	modport source (output valid, data_byte, total_length, input ready);
	modport sink (input valid, data_byte, total_length, output ready);
endinterface

>>> hdl/d4opt_event_if.sv
interface d4opt_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  option_type;
	logic [7:0]  option_length;
	logic [7:0]  value_index;
	logic [7:0]  value_byte;
	logic        option_done;
	logic        buffer_done;
	logic [12:0] consumed;

	modport source (output valid, event_res, option_type, option_length, value_index,
		value_byte, option_done, buffer_done, consumed, input ready);
	modport sink (input valid, event_res, option_type, option_length, value_index,
		value_byte, option_done, buffer_done, consumed, output ready);
endinterface

>>> hdl/d4opt_step.sv
module d4opt_step #(
	parameter int MAX_BUFFER_BYTES = 4096
) (
	input  d4opt_pkg::parse_state_t  st,
	input  logic [7:0]               data_byte,
	input  logic [12:0]              total_length,
	output d4opt_pkg::parse_state_t  nxt,
	output d4opt_pkg::parse_result_t res
);

	localparam int TOTAL_MAX = (1 << d4opt_pkg::TOTAL_W) - 1;
	localparam logic [12:0] LEN_CAP =
		13'((MAX_BUFFER_BYTES > TOTAL_MAX) ? TOTAL_MAX : MAX_BUFFER_BYTES);

	logic [12:0] tot;
	logic [13:0] pos_next;
	logic [13:0] opt_end;
	logic [7:0]  cnt_next;
	logic        last;

	always_comb begin
		// clamp the buffer length into the supported range
		if (total_length > LEN_CAP) begin
			tot = LEN_CAP;
		end else if (total_length == 13'd0) begin
			tot = 13'd1;
		end else begin
			tot = total_length;
		end
		pos_next = {1'b0, st.byte_position} + 14'd1;
		opt_end  = pos_next + {6'b0, data_byte};
		cnt_next = st.value_count + 8'd1;
		last     = (pos_next >= {1'b0, tot});

		nxt = st;
		res = '0;
		res.event_res = d4opt_pkg::EV_IGNORED;

		case (st.phase)
			d4opt_pkg::PH_TYPE: begin
				res.option_type = data_byte;
				if (data_byte == d4opt_pkg::TYPE_END) begin
					res.event_res   = d4opt_pkg::EV_END;
					nxt.stop_offset = st.byte_position;
					nxt.phase       = d4opt_pkg::PH_STOP;
				end else if (data_byte == d4opt_pkg::TYPE_PAD) begin
					res.event_res = d4opt_pkg::EV_PAD;
				end else if (last) begin
					res.event_res   = d4opt_pkg::EV_TRUNC;
					nxt.stop_offset = st.byte_position;
					nxt.phase       = d4opt_pkg::PH_STOP;
				end else begin
					res.event_res    = d4opt_pkg::EV_TYPE;
					nxt.current_type = data_byte;
					nxt.option_start = st.byte_position;
					nxt.phase        = d4opt_pkg::PH_LEN;
				end
			end
			d4opt_pkg::PH_LEN: begin
				res.option_type   = st.current_type;
				res.option_length = data_byte;
				if (opt_end > {1'b0, tot}) begin
					res.event_res   = d4opt_pkg::EV_TRUNC;
					nxt.stop_offset = st.option_start;
					nxt.phase       = d4opt_pkg::PH_STOP;
				end else begin
					res.event_res      = d4opt_pkg::EV_LENGTH;
					nxt.current_length = data_byte;
					nxt.value_count    = 8'd0;
					if (data_byte == 8'd0) begin
						res.option_done = 1'b1;
						nxt.phase       = d4opt_pkg::PH_TYPE;
					end else begin
						nxt.phase = d4opt_pkg::PH_VALUE;
					end
				end
			end
			d4opt_pkg::PH_VALUE: begin
				res.event_res     = d4opt_pkg::EV_VALUE;
				res.option_type   = st.current_type;
				res.option_length = st.current_length;
				res.value_index   = st.value_count;
				res.value_byte    = data_byte;
				nxt.value_count   = cnt_next;
				if (cnt_next >= st.current_length) begin
					res.option_done = 1'b1;
					nxt.phase       = d4opt_pkg::PH_TYPE;
				end
			end
			default: begin
				res.event_res = d4opt_pkg::EV_IGNORED;
			end
		endcase

		if (last) begin
			res.buffer_done = 1'b1;
			if (nxt.phase == d4opt_pkg::PH_STOP) begin
				res.consumed = nxt.stop_offset;
			end else if (nxt.phase == d4opt_pkg::PH_TYPE) begin
				res.consumed = tot;
			end else begin
				res.consumed = nxt.option_start;
			end
			nxt = d4opt_pkg::STATE_RESET;
		end else begin
			nxt.byte_position = pos_next[12:0];
		end
	end

endmodule

>>> hdl/dhcp4_option_tlv_parser.sv
// DHCPv4 options walker. Feed the options buffer one byte per beat on
// "bytes", each beat carrying the buffer's total length; every byte yields
// exactly one beat on "events" (pad, type, length, value, end, truncated, or
// ignored after a stop), and the final byte of a buffer raises buffer_done
// with the consumed offset. The next byte after a final byte starts a new
// buffer at offset 0. The block takes one byte per clock unless the sink stalls:
// a byte is captured in an input register, the per-byte phase logic runs
// between that register and the result register, and a byte's result is
// offered on "events" once it moves from the input register into the result
// register; both registers advance together while the sink keeps up. A total
// length above MAX_BUFFER_BYTES is clamped to it, and zero is treated as one.
module dhcp4_option_tlv_parser #(
	parameter int MAX_BUFFER_BYTES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	d4opt_byte_if.sink    bytes,
	d4opt_event_if.source events
);

	// input register
	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic [12:0] total_length_s1;

	// result register
	logic                     valid_s2;
	d4opt_pkg::parse_result_t result_s2;

	// parse state carried from byte to byte
	d4opt_pkg::parse_state_t  state_q;
	d4opt_pkg::parse_state_t  state_nxt;
	d4opt_pkg::parse_result_t result_nxt;

	logic advance_s1;

	// move the captured byte into the result register when that slot frees up
	assign advance_s1  = valid_s1 && (!valid_s2 || events.ready);
	assign bytes.ready = !valid_s1 || advance_s1;

	d4opt_step #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_step (
		.st           (state_q),
		.data_byte    (data_byte_s1),
		.total_length (total_length_s1),
		.nxt          (state_nxt),
		.res          (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	// capture the incoming byte whenever the input register is free
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_byte_s1    <= bytes.data_byte;
			total_length_s1 <= bytes.total_length;
		end
	end

	// advance the parse state only when a byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= d4opt_pkg::STATE_RESET;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (events.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the result until the sink takes it
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2 <= result_nxt;
		end
	end

	assign events.valid         = valid_s2;
	assign events.event_res     = result_s2.event_res;
	assign events.option_type   = result_s2.option_type;
	assign events.option_length = result_s2.option_length;
	assign events.value_index   = result_s2.value_index;
	assign events.value_byte    = result_s2.value_byte;
	assign events.option_done   = result_s2.option_done;
	assign events.buffer_done   = result_s2.buffer_done;
	assign events.consumed      = result_s2.consumed;

endmodule
